@@ sv/mipft_pkg.sv @@
// shared types, codes and helpers of the masked ip filter table
package mipft_pkg;

  // widths fixed by the interface
  localparam int unsigned OCTETS_W   = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 11;
  // widest table index for the largest supported capacity
  localparam int unsigned MEM_ADDR_W = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_APPEND,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // table memory request
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [MEM_ADDR_W-1:0] waddr;
    logic [MEM_ADDR_W-1:0] raddr;
    logic [OCTETS_W-1:0]   wdata;
  } mem_req_t;

  // one finished result
  typedef struct packed {
    logic                refuse;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } res_t;

  // bit mask with 0xff in every byte where the pattern octet is nonzero
  function automatic logic [OCTETS_W-1:0] care_mask(input logic [OCTETS_W-1:0] octets);
    logic [OCTETS_W-1:0] m;
    m = '0;
    for (int b = 0; b < 4; b++) begin
      if (octets[8*b +: 8] != 8'h00) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

@@ sv/mipft_ram.sv @@
// single-port-write, registered-read memory that holds the filter entries
module mipft_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned IDX_W = 10
) (
  input  logic                           clk,
  input  mipft_pkg::mem_req_t            mem_req,
  output logic [mipft_pkg::OCTETS_W-1:0] mem_rdata
);
  import mipft_pkg::*;

  logic [OCTETS_W-1:0] mem [DEPTH];
  logic [OCTETS_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr[IDX_W-1:0]] <= mem_req.wdata;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata_r <= mem[mem_req.raddr[IDX_W-1:0]];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

@@ sv/mipft_ctrl.sv @@
// sequencer that walks the table for lookup, append and remove with shift
module mipft_ctrl #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned CNT_W    = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ban_mode,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mipft_pkg::OP_W-1:0]     in_operation,
  input  logic [mipft_pkg::OCTETS_W-1:0] in_address,
  input  logic [mipft_pkg::OCTETS_W-1:0] in_pattern,
  output logic                           res_valid,
  input  logic                           res_ready,
  output mipft_pkg::res_t                res,
  output mipft_pkg::mem_req_t            mem_req,
  input  logic [mipft_pkg::OCTETS_W-1:0] mem_rdata
);
  import mipft_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [OCTETS_W-1:0] key_r, key_nxt;
  logic                refuse_r, refuse_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic [CNT_W-1:0]    i_inc;
  logic                hit;

  assign i_inc = i_r + ONE;

  // entry check: masked compare for lookup, exact compare for remove
  always_comb begin
    if (op_r == OP_LOOKUP) begin
      hit = (key_r & care_mask(mem_rdata)) == mem_rdata;
    end else begin
      hit = key_r == mem_rdata;
    end
  end

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    refuse_nxt = refuse_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          key_nxt    = (in_operation == OP_LOOKUP) ? in_address : in_pattern;
          i_nxt      = '0;
          refuse_nxt = 1'b0;
          status_nxt = ST_DONE;
          unique case (in_operation)
            OP_LOOKUP: begin
              if (count_r == '0) begin
                refuse_nxt = ~ban_mode;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_ADD: begin
              if (count_r >= CAP) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_APPEND;
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_NOT_FOUND;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (op_r == OP_LOOKUP) begin
          if (hit) begin
            refuse_nxt = ban_mode;
            state_nxt  = S_DONE;
          end else if (i_inc == count_r) begin
            refuse_nxt = ~ban_mode;
            state_nxt  = S_DONE;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_READ;
          end
        end else begin
          if (hit) begin
            i_nxt = i_inc;
            if (i_inc == count_r) begin
              count_nxt = count_r - ONE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SHIFT_RD;
            end
          end else if (i_inc == count_r) begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_READ;
          end
        end
      end
      S_APPEND: begin
        count_nxt = count_r + ONE;
        state_nxt = S_DONE;
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        i_nxt = i_inc;
        if (i_inc == count_r) begin
          count_nxt = count_r - ONE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // handshake and memory request outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_READ, S_SHIFT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = MEM_ADDR_W'(i_r);
      end
      S_APPEND: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MEM_ADDR_W'(count_r);
        mem_req.wdata = key_r;
      end
      S_SHIFT_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MEM_ADDR_W'(i_r - ONE);
        mem_req.wdata = mem_rdata;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign res.refuse      = refuse_r;
  assign res.status      = status_r;
  assign res.entry_count = COUNT_W'(count_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    refuse_r <= refuse_nxt;
    status_r <= status_nxt;
  end

  // the table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("entry count above capacity");

  // writes happen only when appending or shifting
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_APPEND || state_r == S_SHIFT_WR))
    else $error("table write outside append or shift");

  // a shift write always targets the slot below the one just read
  a_shift_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT_WR |-> $past(state_r) == S_SHIFT_RD && i_r != '0
                              && $past(mem_req.raddr) == MEM_ADDR_W'(i_r))
    else $error("shift write not paired with its read");

  // the count changes only at the end of an add or remove
  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> state_r == S_DONE)
    else $error("entry count changed mid item");

  // once a result is handed off the sequencer is free again
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> in_ready)
    else $error("sequencer not idle after result handoff");

endmodule

@@ sv/masked_ip_filter_table_top.sv @@
// top level of the masked ip filter table: config register, result register, table
// add: appends the pattern at the end of the table, or reports full; op code 3 gives a plain done result
// lookup: reads and checks entries in order until a hit or the last entry; an empty table is not read
// remove: finds the first exact match, then moves each later entry down one slot, a read then a write
// one request in flight at a time; the next is taken while the result waits at out_*
// reset empties the table (count zero) and sets ban_mode to 1; no clearing pass
module masked_ip_filter_table_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_ban_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_address,
  input  logic [31:0] in_pattern,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_refuse,
  output logic [1:0]  out_status,
  output logic [10:0] out_entry_count
);
  import mipft_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                ban_mode_r;
  logic                out_valid_r;
  res_t                out_res_r;
  logic                res_valid;
  logic                res_ready;
  res_t                res;
  mem_req_t            mem_req;
  logic [OCTETS_W-1:0] mem_rdata;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ban_mode_r <= 1'b1;
    end else if (cfg_valid) begin
      ban_mode_r <= cfg_ban_mode;
    end
  end

  mipft_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .ban_mode     (ban_mode_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_address   (in_address),
    .in_pattern   (in_pattern),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  mipft_ram #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // output register decouples the sequencer from the result consumer
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_refuse      = out_res_r.refuse;
  assign out_status      = out_res_r.status;
  assign out_entry_count = out_res_r.entry_count;

endmodule

@@ bench/tb_masked_ip_filter_table_top.sv @@
// testbench of the masked ip filter table: directed, random and deep-table requests
module tb_masked_ip_filter_table_top;
  import mipft_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned IDLE_PCT = 35;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_ban_mode = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = '0;
  logic [31:0] in_address = '0;
  logic [31:0] in_pattern = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_refuse;
  logic [1:0]  out_status;
  logic [10:0] out_entry_count;

  // local copy of the table and the ban mode register
  logic [31:0] filter_entries[$];
  logic        ban_mode_now = 1'b1;
  // verdicts still owed by the block, oldest first
  res_t        owed_verdicts[$];
  int unsigned mismatches = 0;
  bit          quiet_run = 1'b0;

  masked_ip_filter_table_top #(
    .CAPACITY(TABLE_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_ban_mode    (cfg_ban_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_address      (in_address),
    .in_pattern      (in_pattern),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_refuse      (out_refuse),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always #1 clk = ~clk;

  // 0xff in every byte whose octet is nonzero
  function automatic logic [31:0] octet_care_bits(logic [31:0] octets);
    logic [31:0] bits;
    for (int b = 0; b < 4; b++) begin
      bits[8*b +: 8] = {8{|octets[8*b +: 8]}};
    end
    return bits;
  endfunction

  // apply one request to the local table and work out the verdict it owes
  function automatic res_t apply_filter_request(logic [1:0] op, logic [31:0] addr,
                                                logic [31:0] pat);
    res_t verdict;
    bit   hit;
    int   found;
    verdict = '0;
    hit = 1'b0;
    found = -1;
    case (op)
      OP_LOOKUP: begin
        foreach (filter_entries[k]) begin
          if ((addr & octet_care_bits(filter_entries[k])) == filter_entries[k]) hit = 1'b1;
        end
        verdict.refuse = hit ? ban_mode_now : ~ban_mode_now;
      end
      OP_ADD: begin
        if (filter_entries.size() >= TABLE_DEPTH) verdict.status = ST_FULL;
        else filter_entries.push_back(pat);
      end
      OP_REMOVE: begin
        foreach (filter_entries[k]) begin
          if (found < 0 && filter_entries[k] == pat) found = k;
        end
        if (found < 0) verdict.status = ST_NOT_FOUND;
        else filter_entries.delete(found);
      end
      default: begin
      end
    endcase
    verdict.entry_count = COUNT_W'(filter_entries.size());
    return verdict;
  endfunction

  // pattern with some wildcard octets, some all-ones octets and the rest random nonzero
  function automatic logic [31:0] random_pattern();
    logic [31:0] p;
    int unsigned roll;
    for (int b = 0; b < 4; b++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) p[8*b +: 8] = 8'h00;
      else if (roll < 40) p[8*b +: 8] = 8'hFF;
      else p[8*b +: 8] = 8'($urandom_range(1, 255));
    end
    return p;
  endfunction

  // flip one bit inside a cared octet of an entry; a random value for an all-wildcard entry
  function automatic logic [31:0] near_miss(logic [31:0] entry);
    int unsigned b;
    if (entry == '0) return $urandom();
    b = $urandom_range(0, 3);
    while (entry[8*b +: 8] == 8'h00) b = (b + 1) % 4;
    return entry ^ (32'h1 << (8 * b + $urandom_range(0, 7)));
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // one request on the input channel; predicted at acceptance
  task automatic send_request(logic [1:0] op, logic [31:0] addr, logic [31:0] pat);
    while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_address   <= addr;
    in_pattern   <= pat;
    do @(posedge clk); while (!in_ready);
    owed_verdicts.push_back(apply_filter_request(op, addr, pat));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (owed_verdicts.size() != 0) @(posedge clk);
  endtask

  // ban mode write, only with the block idle
  task automatic set_ban_mode(logic mode);
    wait_for_drain();
    cfg_ban_mode <= mode;
    cfg_valid    <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    ban_mode_now = mode;
  endtask

  // empty table, extreme values, wildcards, duplicates, unused code
  task automatic test_directed_requests();
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0100_A8C0);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_ADD,    32'hFFFF_FFFF, 32'h0000_A8C0);
    send_request(OP_ADD,    32'h0000_0000, 32'h0000_A8C0);
    send_request(OP_ADD,    32'h0000_0000, 32'h0000_000A);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h1234_A8C0, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FF0A, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h0000_A8C1, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_A8C0);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_A8C0);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_A8C0);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0001_A8C0);
    send_request(OP_ADD,    32'h0000_0000, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_000A);
    send_request(OP_LOOKUP, 32'h0000_000A, 32'h0000_0000);
  endtask

  // lookups mostly near stored entries, adds, removes mostly of stored patterns, and unused codes
  task automatic test_random_traffic(int n_items);
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] pat;
    logic [31:0] entry;
    int unsigned roll;
    int unsigned add_limit;
    for (int n = 0; n < n_items; n++) begin
      addr  = $urandom();
      pat   = random_pattern();
      entry = (filter_entries.size() > 0) ?
              filter_entries[$urandom_range(0, filter_entries.size() - 1)] : $urandom();
      // keep the table short so scans stay quick
      add_limit = (filter_entries.size() >= 40) ? 55 : 78;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        op = OP_UNUSED;
      end else if (roll < 50) begin
        op = OP_LOOKUP;
        roll = $urandom_range(0, 99);
        if (roll < 55) addr = entry | (addr & ~octet_care_bits(entry));
        else if (roll < 80) addr = near_miss(entry);
      end else if (roll < add_limit) begin
        op = OP_ADD;
      end else begin
        op = OP_REMOVE;
        roll = $urandom_range(0, 99);
        if (roll < 70) pat = entry;
        else if (roll < 85) pat = near_miss(entry);
      end
      send_request(op, addr, pat);
    end
  endtask

  // grow the table deeper, long scans and removes near its end
  task automatic test_deep_table();
    logic [31:0] fill_pat;
    logic [31:0] last_entry;
    repeat (24) begin
      fill_pat = random_pattern();
      send_request(OP_ADD, $urandom(), {fill_pat[31:8], 8'h0A});
    end
    send_request(OP_LOOKUP, 32'h0B0B_0B0B, 32'h0000_0000);
    last_entry = filter_entries[$];
    send_request(OP_LOOKUP, last_entry, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, last_entry);
    send_request(OP_ADD,    32'h0000_0000, 32'h0102_0304);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0C0C_0C0C);
    set_ban_mode(1'b0);
    send_request(OP_LOOKUP, 32'h0B0B_0B0B, 32'h0000_0000);
  endtask

  // result side stalls
  always @(posedge clk) begin
    out_ready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare every accepted verdict with the oldest one owed
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_verdicts.size() == 0) begin
        note_mismatch("unexpected verdict, count", '0, 32'(out_entry_count));
      end else begin
        want = owed_verdicts.pop_front();
        if (out_refuse !== want.refuse) begin
          note_mismatch("refuse", 32'(want.refuse), 32'(out_refuse));
        end
        if (out_status !== want.status) begin
          note_mismatch("status", 32'(want.status), 32'(out_status));
        end
        if (out_entry_count !== want.entry_count) begin
          note_mismatch("entry_count", 32'(want.entry_count), 32'(out_entry_count));
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_requests();
    set_ban_mode(1'b0);
    test_random_traffic(80);
    set_ban_mode(1'b1);
    quiet_run = 1'b1;
    test_random_traffic(70);
    set_ban_mode(1'($urandom_range(0, 1)));
    quiet_run = 1'b0;
    test_random_traffic(80);
    set_ban_mode(1'b1);
    test_deep_table();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_verdicts.size() == 0) begin
      $display("PASS masked_ip_filter_table_top");
    end else begin
      $display("FAIL masked_ip_filter_table_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #1500000;
    $display("FAIL masked_ip_filter_table_top");
    $finish;
  end

endmodule
